// ===== rtl/mnte_pkg.sv =====
// ----------------------------------------------------------------------------
// mnte_pkg
// shared constants and types of the node table engine
// ----------------------------------------------------------------------------
package mnte_pkg;

    localparam int NODES     = 32;
    localparam int SLOT_W    = $clog2(NODES);
    localparam int CNT_W     = $clog2(NODES + 1);
    localparam int QDEPTH    = 2;

    localparam logic [15:0] MAX_GROUP   = 16'hfeff;
    localparam logic [7:0]  NO_SELECTOR = 8'hff;

    localparam logic [2:0] OP_UPSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_ASSIGN = 3'd3;
    localparam logic [2:0] OP_FREE   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [1:0] REG_PROV  = 2'd0;
    localparam logic [1:0] REG_GBASE = 2'd1;
    localparam logic [1:0] REG_SELM  = 2'd2;

    typedef struct packed {
        logic [15:0] model;
        logic [15:0] unicast;
        logic        configured;
        logic [15:0] group;
        logic [15:0] company;
        logic [15:0] vendor_model;
        logic [7:0]  selector;
    } rec_t;

    // classified command handed from front to back
    typedef struct packed {
        logic        valid_op;
        logic [2:0]  op;
        logic [31:0] key;
        rec_t        rec;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_count;
        rec_t        rec;
        logic [15:0] effective_group;
        logic [7:0]  free_selector;
    } res_t;

endpackage

// ===== rtl/mnte_front.sv =====
// ----------------------------------------------------------------------------
// mnte_front
// accepts input transfers, classifies the op and queues commands
// ----------------------------------------------------------------------------
module mnte_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mnte_pkg::cmd_t in_cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output mnte_pkg::cmd_t q_cmd
);
    import mnte_pkg::*;

    cmd_t                  fifo_reg [QDEPTH];
    logic [$clog2(QDEPTH):0] cnt_reg;
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    cmd_t                  cls;
    logic                  push, pop;

    always_comb
    begin
        cls = in_cmd;
        cls.valid_op = (in_cmd.op <= OP_FREE);
    end

    assign in_ready = (cnt_reg != ($clog2(QDEPTH)+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = fifo_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/mnte_back.sv =====
// ----------------------------------------------------------------------------
// mnte_back
// sequencer that searches, edits and scans the record table
// ----------------------------------------------------------------------------
module mnte_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mnte_pkg::cmd_t q_cmd,
    input  logic [15:0]    prov,
    input  logic [15:0]    gbase,
    input  logic [15:0]    selm,
    output logic           res_valid,
    input  logic           res_ready,
    output mnte_pkg::res_t res
);
    import mnte_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SRCH, S_EXEC, S_SHIFT, S_FREE, S_OUT} state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic [254:0]       used_reg;
    res_t               res_reg;
    logic               rv_reg;

    logic [31:0]        key_mem [NODES];
    rec_t               rec_mem [NODES];

    logic [SLOT_W-1:0]  ip;
    rec_t               cur;
    logic [16:0]        sum;
    logic [15:0]        eff;
    logic [7:0]         fs;
    logic               fs_hit;

    assign ip  = idx_reg[SLOT_W-1:0];
    assign cur = rec_mem[slot_reg];
    // a new command starts only once the previous result has been taken
    assign q_ready   = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        sum = {1'b0, gbase} + {1'b0, cur.unicast} - {1'b0, prov};
        if (cur.group != 16'd0)
            eff = cur.group;
        else if (cur.unicast <= prov || sum > {1'b0, MAX_GROUP})
            eff = 16'd0;
        else
            eff = sum[15:0];
    end

    // priority encode over the used map, lowest free index wins; result taken at the end of the free scan
    always_comb
    begin
        fs     = NO_SELECTOR;
        fs_hit = 1'b0;
        for (int i = 0; i < 255; i++)
        begin
            if (!fs_hit && !used_reg[i])
            begin
                fs     = 8'(i);
                fs_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && hit_reg)
        begin
            if (cmd_reg.op == OP_UPSERT)
            begin
                key_mem[slot_reg] <= cmd_reg.key;
                rec_mem[slot_reg] <= cmd_reg.rec;
            end
            else if (cmd_reg.op == OP_ASSIGN && !cur.configured &&
                     cmd_reg.rec.company != 16'd0)
            begin
                rec_mem[slot_reg].company      <= cmd_reg.rec.company;
                rec_mem[slot_reg].vendor_model <= cmd_reg.rec.vendor_model;
                rec_mem[slot_reg].group        <= eff;
            end
        end
        if (state_reg == S_SHIFT && idx_reg < cnt_reg)
        begin
            key_mem[ip - 1'b1] <= key_mem[ip];
            rec_mem[ip - 1'b1] <= rec_mem[ip];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            idx_reg   <= '0;
            slot_reg  <= '0;
            hit_reg   <= 1'b0;
            used_reg  <= '0;
            cmd_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (rv_reg && res_ready)
                rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && !rv_reg)
                    begin
                        cmd_reg   <= q_cmd;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        used_reg  <= '0;
                        if (!q_cmd.valid_op)
                        begin
                            res_reg   <= '{status: ST_REJECTED, entry_count: 6'(cnt_reg),
                                           free_selector: NO_SELECTOR, default: '0};
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            res_reg <= '{free_selector: NO_SELECTOR, default: '0};
                            if (q_cmd.op == OP_FREE)
                                state_reg <= S_FREE;
                            else
                                state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (idx_reg < cnt_reg && key_mem[ip] == cmd_reg.key)
                    begin
                        slot_reg  <= ip;
                        hit_reg   <= 1'b1;
                        state_reg <= S_EXEC;
                    end
                    else if (idx_reg >= cnt_reg)
                    begin
                        slot_reg  <= ip;
                        state_reg <= S_EXEC;
                        if (cmd_reg.op == OP_UPSERT && cnt_reg < CNT_W'(NODES))
                            hit_reg <= 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_EXEC:
                begin
                    case (cmd_reg.op)
                        OP_UPSERT:
                        begin
                            state_reg <= S_OUT;
                            if (!hit_reg)
                            begin
                                res_reg.status      <= ST_FULL;
                                res_reg.entry_count <= 6'(cnt_reg);
                            end
                            else if (idx_reg >= cnt_reg)
                            begin
                                res_reg.status      <= ST_OK;
                                cnt_reg             <= cnt_reg + 1'b1;
                                res_reg.entry_count <= 6'(cnt_reg + 1'b1);
                            end
                            else
                            begin
                                res_reg.status      <= ST_OK;
                                res_reg.entry_count <= 6'(cnt_reg);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_reg)
                            begin
                                res_reg.status      <= ST_NOTFOUND;
                                res_reg.entry_count <= 6'(cnt_reg);
                                state_reg           <= S_OUT;
                            end
                            else
                            begin
                                res_reg.status <= ST_OK;
                                idx_reg        <= idx_reg + 1'b1;
                                state_reg      <= S_SHIFT;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_reg           <= S_OUT;
                            res_reg.entry_count <= 6'(cnt_reg);
                            if (!hit_reg)
                                res_reg.status <= ST_NOTFOUND;
                            else
                            begin
                                res_reg.status          <= ST_OK;
                                res_reg.rec             <= cur;
                                res_reg.effective_group <= eff;
                            end
                        end
                        default:
                        begin
                            state_reg           <= S_OUT;
                            res_reg.entry_count <= 6'(cnt_reg);
                            if (!hit_reg)
                                res_reg.status <= ST_NOTFOUND;
                            else if (cur.configured || cmd_reg.rec.company == 16'd0)
                                res_reg.status <= ST_REJECTED;
                            else
                                res_reg.status <= ST_OK;
                        end
                    endcase
                end
                S_SHIFT:
                begin
                    if (idx_reg < cnt_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        res_reg.entry_count <= 6'(cnt_reg - 1'b1);
                        state_reg <= S_OUT;
                    end
                end
                S_FREE:
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        if (rec_mem[ip].model == selm &&
                            rec_mem[ip].selector != NO_SELECTOR)
                            used_reg[rec_mem[ip].selector] <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        res_reg.status      <= ST_OK;
                        res_reg.entry_count <= 6'(cnt_reg);
                        res_reg.free_selector <= fs;
                        state_reg <= S_OUT;
                    end
                end
                default:
                begin
                    if (!rv_reg)
                    begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/mesh_node_table_engine.sv =====
// ----------------------------------------------------------------------------
// mesh_node_table_engine
// compacted node record table with upsert, remove, lookup and selector scan
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         one op with key and record fields
//  m_axis    out        status, count, looked-up record, free selector
//  apb       in         three 16-bit configuration registers
//
// a key search walks one slot per cycle, a remove then shifts one slot per
// cycle, and a free selector op walks all stored records once; the back
// part's sequencer runs these walks.
// reset clears the count and registers; record stores hold no reset.
// the back part starts an op only after the previous result transfer;
// a two-entry queue lets input transfers pile up while results stall.
module mesh_node_table_engine
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[2:0] instance_id[34:3] model[50:35] unicast_address[66:51]
    // configured[67] control_group_address[83:68] vendor_company_id[99:84]
    // vendor_model_id[115:100] routing_selector[123:116]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0] entry_count[7:2] found_model[23:8] found_unicast[39:24]
    // found_configured[40] found_group[56:41] effective_group[72:57]
    // found_company[88:73] found_vendor_model[104:89] found_selector[112:105]
    // free_selector[120:113]
    output logic [127:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mnte_pkg::*;

    logic [15:0] prov_reg, gbase_reg, selm_reg;
    cmd_t        in_cmd, q_cmd;
    logic        q_valid, q_ready;
    res_t        res;

    assign pready = 1'b1;

    // register writes at the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prov_reg  <= '0;
            gbase_reg <= '0;
            selm_reg  <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_PROV:  prov_reg  <= pwdata[15:0];
                REG_GBASE: gbase_reg <= pwdata[15:0];
                REG_SELM:  selm_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_PROV:  prdata = {16'd0, prov_reg};
                REG_GBASE: prdata = {16'd0, gbase_reg};
                REG_SELM:  prdata = {16'd0, selm_reg};
                default:   prdata = '0;
            endcase
        end
    end

    // unpack the input transfer
    always_comb
    begin
        in_cmd                  = '0;
        in_cmd.op               = s_axis_tdata[2:0];
        in_cmd.key              = s_axis_tdata[34:3];
        in_cmd.rec.model        = s_axis_tdata[50:35];
        in_cmd.rec.unicast      = s_axis_tdata[66:51];
        in_cmd.rec.configured   = s_axis_tdata[67];
        in_cmd.rec.group        = s_axis_tdata[83:68];
        in_cmd.rec.company      = s_axis_tdata[99:84];
        in_cmd.rec.vendor_model = s_axis_tdata[115:100];
        in_cmd.rec.selector     = s_axis_tdata[123:116];
    end

    mnte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    mnte_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .prov      (prov_reg),
        .gbase     (gbase_reg),
        .selm      (selm_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result transfer
    assign m_axis_tdata = {7'd0, res.free_selector, res.rec.selector,
                           res.rec.vendor_model, res.rec.company,
                           res.effective_group, res.rec.group,
                           res.rec.configured, res.rec.unicast, res.rec.model,
                           res.entry_count, res.status};

endmodule

// ===== sim/tb_mesh_node_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_mesh_node_table_engine
// self-checking bench for the node table engine: a queue-fed stream driver,
// an apb register writer, a table predictor and a result monitor
// ----------------------------------------------------------------------------
module tb_mesh_node_table_engine;

    import mnte_pkg::*;

    // one op as it goes into the block
    typedef struct {
        logic [2:0]  op;
        logic [31:0] key;
        logic [15:0] model;
        logic [15:0] unicast;
        logic        configured;
        logic [15:0] group;
        logic [15:0] company;
        logic [15:0] vendor_model;
        logic [7:0]  selector;
    } node_op_t;

    // one result as it comes out of the block
    typedef struct {
        logic [1:0]  status;
        logic [5:0]  count;
        logic [15:0] model;
        logic [15:0] unicast;
        logic        configured;
        logic [15:0] group;
        logic [15:0] eff_group;
        logic [15:0] company;
        logic [15:0] vendor_model;
        logic [7:0]  selector;
        logic [7:0]  free_sel;
    } node_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    mesh_node_table_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predicted table contents and register copies
    logic [31:0] tbl_key      [NODES];
    logic [15:0] tbl_model    [NODES];
    logic [15:0] tbl_unicast  [NODES];
    logic        tbl_conf     [NODES];
    logic [15:0] tbl_group    [NODES];
    logic [15:0] tbl_company  [NODES];
    logic [15:0] tbl_vmodel   [NODES];
    logic [7:0]  tbl_selector [NODES];
    int          tbl_count;
    logic [15:0] prov_addr;
    logic [15:0] group_base;
    logic [15:0] sel_model;

    node_op_t    pending_ops[$];
    node_res_t   expected_results[$];
    node_op_t    cur_op;
    int          errors;
    int          results_seen;
    int          ops_sent;
    int          tx_idle_left;
    int          rx_idle_left;
    bit          idling_on;
    bit          long_hold_req;
    int          long_hold_left;
    int          full_seen;
    logic [31:0] key_pool[40];

    // clock, 2 time units per period
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop on a hang
    initial
    begin
        #3000000;
        $display("timeout at %0t", $time);
        $display("tb_mesh_node_table_engine failed");
        $finish;
    end

    function automatic logic [127:0] pack_op(node_op_t o);
        return {4'b0, o.selector, o.vendor_model, o.company, o.group, o.configured,
                o.unicast, o.model, o.key, o.op};
    endfunction

    // effective group of a predicted slot, no wrap on the sum
    function automatic logic [15:0] effective_group_of(int s);
        int sum;
        if (tbl_group[s] != 16'd0)
            return tbl_group[s];
        if (tbl_unicast[s] <= prov_addr)
            return 16'd0;
        sum = int'(group_base) + int'(tbl_unicast[s]) - int'(prov_addr);
        return (sum <= int'(MAX_GROUP)) ? 16'(sum) : 16'd0;
    endfunction

    // run one op against the predicted table and queue its result
    task automatic predict_op(node_op_t o);
        node_res_t   r;
        int          s;
        bit          used[255];
        r = '{default: '0};
        r.free_sel = NO_SELECTOR;
        r.status = ST_OK;
        s = NODES;
        for (int i = tbl_count - 1; i >= 0; i--)
            if (tbl_key[i] == o.key)
                s = i;
        case (o.op)
            OP_UPSERT:
            begin
                if (s == NODES)
                begin
                    if (tbl_count >= NODES)
                        r.status = ST_FULL;
                    else
                    begin
                        s = tbl_count;
                        tbl_count++;
                    end
                end
                if (r.status == ST_OK)
                begin
                    tbl_key[s]      = o.key;
                    tbl_model[s]    = o.model;
                    tbl_unicast[s]  = o.unicast;
                    tbl_conf[s]     = o.configured;
                    tbl_group[s]    = o.group;
                    tbl_company[s]  = o.company;
                    tbl_vmodel[s]   = o.vendor_model;
                    tbl_selector[s] = o.selector;
                end
                else
                    full_seen++;
            end
            OP_REMOVE:
            begin
                if (s == NODES)
                    r.status = ST_NOTFOUND;
                else
                begin
                    // compaction: later records move down one slot
                    for (int i = s + 1; i < tbl_count; i++)
                    begin
                        tbl_key[i-1]      = tbl_key[i];
                        tbl_model[i-1]    = tbl_model[i];
                        tbl_unicast[i-1]  = tbl_unicast[i];
                        tbl_conf[i-1]     = tbl_conf[i];
                        tbl_group[i-1]    = tbl_group[i];
                        tbl_company[i-1]  = tbl_company[i];
                        tbl_vmodel[i-1]   = tbl_vmodel[i];
                        tbl_selector[i-1] = tbl_selector[i];
                    end
                    tbl_count--;
                end
            end
            OP_LOOKUP:
            begin
                if (s == NODES)
                    r.status = ST_NOTFOUND;
                else
                begin
                    r.model        = tbl_model[s];
                    r.unicast      = tbl_unicast[s];
                    r.configured   = tbl_conf[s];
                    r.group        = tbl_group[s];
                    r.eff_group    = effective_group_of(s);
                    r.company      = tbl_company[s];
                    r.vendor_model = tbl_vmodel[s];
                    r.selector     = tbl_selector[s];
                end
            end
            OP_ASSIGN:
            begin
                if (s == NODES)
                    r.status = ST_NOTFOUND;
                else if (tbl_conf[s] || o.company == 16'd0)
                    r.status = ST_REJECTED;
                else
                begin
                    tbl_company[s] = o.company;
                    tbl_vmodel[s]  = o.vendor_model;
                    tbl_group[s]   = effective_group_of(s);
                end
            end
            OP_FREE:
            begin
                foreach (used[i])
                    used[i] = 1'b0;
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_model[i] == sel_model && tbl_selector[i] != NO_SELECTOR)
                        used[tbl_selector[i]] = 1'b1;
                r.free_sel = NO_SELECTOR;
                for (int i = 254; i >= 0; i--)
                    if (!used[i])
                        r.free_sel = 8'(i);
            end
            default:
                r.status = ST_REJECTED;
        endcase
        r.count = 6'(tbl_count);
        expected_results.push_back(r);
    endtask

    // stream driver: offers queued ops, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_idle_left  = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_op(cur_op);
                ops_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;   // hold the offered op
            else if (tx_idle_left > 0)
            begin
                tx_idle_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                cur_op = pending_ops.pop_front();
                s_axis_tdata  <= pack_op(cur_op);
                s_axis_tvalid <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0)
                    tx_idle_left = $urandom_range(1, 12);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: mismatch in %s, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor: compares each transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        node_res_t e;
        logic [127:0] d;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_idle_left   = 0;
            long_hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                d = m_axis_tdata;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, d);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status", 32'(e.status), 32'(d[1:0]));
                    check_field("entry_count", 32'(e.count), 32'(d[7:2]));
                    check_field("found_model", 32'(e.model), 32'(d[23:8]));
                    check_field("found_unicast", 32'(e.unicast), 32'(d[39:24]));
                    check_field("found_configured", 32'(e.configured), 32'(d[40]));
                    check_field("found_group", 32'(e.group), 32'(d[56:41]));
                    check_field("effective_group", 32'(e.eff_group), 32'(d[72:57]));
                    check_field("found_company", 32'(e.company), 32'(d[88:73]));
                    check_field("found_vendor_model", 32'(e.vendor_model),
                                32'(d[104:89]));
                    check_field("found_selector", 32'(e.selector), 32'(d[112:105]));
                    check_field("free_selector", 32'(e.free_sel), 32'(d[120:113]));
                end
            end
            // long receiver stall so the input side fills up
            if (long_hold_req && long_hold_left == 0)
            begin
                long_hold_req  = 1'b0;
                long_hold_left = 400;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_left > 0)
            begin
                rx_idle_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0)
                    rx_idle_left = $urandom_range(1, 12);
            end
        end
    end

    // apb write: setup cycle then access cycle
    task automatic reg_write(logic [1:0] idx, logic [15:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(0, 65535)), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROV:  prov_addr  = v;
            REG_GBASE: group_base = v;
            default:   sel_model  = v;
        endcase
    endtask

    task automatic set_regs(logic [15:0] p, logic [15:0] g, logic [15:0] m);
        reg_write(REG_PROV, p);
        reg_write(REG_GBASE, g);
        reg_write(REG_SELM, m);
    endtask

    // wait until every offered op has its result, then let the engine settle
    // sampled at the falling edge so the driver and monitor have settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
        repeat (60) @(posedge clk);
    endtask

    function automatic node_op_t mk_op(logic [2:0] op, logic [31:0] key, logic [15:0] model,
                                       logic [15:0] uni, logic conf, logic [15:0] grp,
                                       logic [15:0] comp, logic [15:0] vm, logic [7:0] sel);
        node_op_t o;
        o.op = op; o.key = key; o.model = model; o.unicast = uni; o.configured = conf;
        o.group = grp; o.company = comp; o.vendor_model = vm; o.selector = sel;
        return o;
    endfunction

    // random op biased toward table hits and the interesting corners
    function automatic node_op_t rand_op(int upsert_weight);
        node_op_t o;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < upsert_weight)               o.op = OP_UPSERT;
        else if (pick < upsert_weight + 12)     o.op = OP_REMOVE;
        else if (pick < upsert_weight + 32)     o.op = OP_LOOKUP;
        else if (pick < upsert_weight + 44)     o.op = OP_ASSIGN;
        else if (pick < 97)                     o.op = OP_FREE;
        else                                    o.op = 3'($urandom_range(5, 7));
        o.key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 39)];
        o.model = ($urandom_range(0, 2) != 0) ? sel_model : 16'($urandom());
        case ($urandom_range(0, 3))
            0:       o.unicast = prov_addr;
            1:       o.unicast = prov_addr + 16'($urandom_range(1, 64));
            2:       o.unicast = prov_addr - 16'($urandom_range(1, 64));
            default: o.unicast = 16'($urandom());
        endcase
        o.configured   = 1'($urandom());
        o.group        = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom());
        o.company      = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom());
        o.vendor_model = 16'($urandom());
        case ($urandom_range(0, 3))
            0:       o.selector = NO_SELECTOR;
            1:       o.selector = 8'($urandom());
            default: o.selector = 8'($urandom_range(0, 6));
        endcase
        return o;
    endfunction

    initial
    begin
        logic [15:0] cfg_p[8];
        logic [15:0] cfg_g[8];
        logic [15:0] cfg_m[8];
        errors = 0; results_seen = 0; ops_sent = 0; full_seen = 0;
        tbl_count = 0; prov_addr = 0; group_base = 0; sel_model = 0;
        idling_on = 1'b1; long_hold_req = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: field extremes, every op and the refusal paths
        set_regs(16'h0010, 16'hc000, 16'h1234);
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_FREE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_UPSERT, 32'h0, 16'h1234, 16'h0020, 0, 0, 0, 0, 8'd0));
        pending_ops.push_back(mk_op(OP_UPSERT, 32'hffffffff, 16'hffff, 16'hffff, 1,
                                    16'hffff, 16'hffff, 16'hffff, 8'hff));
        pending_ops.push_back(mk_op(OP_UPSERT, 32'h5, 16'h1234, 16'h0008, 0, 0, 0, 0, 8'd1));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h5, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h77, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_FREE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_ASSIGN, 32'h77, 0, 0, 0, 0, 16'h0059, 16'h1, 0));
        pending_ops.push_back(mk_op(OP_ASSIGN, 32'h0, 0, 0, 0, 0, 16'h0, 16'h1, 0));
        pending_ops.push_back(mk_op(OP_ASSIGN, 32'hffffffff, 0, 0, 0, 0, 16'h0059, 16'h1, 0));
        pending_ops.push_back(mk_op(OP_ASSIGN, 32'h0, 0, 0, 0, 0, 16'hffff, 16'hffff, 0));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_REMOVE, 32'h77, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_REMOVE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(OP_LOOKUP, 32'h5, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(3'd5, 32'h5, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(3'd6, 32'h5, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(mk_op(3'd7, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // random phases; first and second settings are the register extremes
        cfg_p = '{16'h0000, 16'hffff, 16'h0100, 16'h0000, 16'h8000, 16'h0001, 16'h00ff, 16'h7fff};
        cfg_g = '{16'h0000, 16'hffff, 16'hfe00, 16'hfef0, 16'h4000, 16'hc000, 16'h0000, 16'h8000};
        cfg_m = '{16'h0000, 16'hffff, 16'h1234, 16'h0000, 16'h00aa, 16'h1234, 16'h8001, 16'h5555};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph >= 6)
                set_regs(16'($urandom()), 16'($urandom()), cfg_m[ph]);
            else
                set_regs(cfg_p[ph], cfg_g[ph], cfg_m[ph]);
            foreach (key_pool[i])
                key_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hffffffff : $urandom();
            idling_on = (ph != 7);
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < 166; n++)
                pending_ops.push_back(rand_op((ph % 2 == 0) ? 50 : 30));
            drain();
        end

        $display("ran %0d ops with %0d results checked over 9 register settings", ops_sent,
                 results_seen);
        $display("table-full refusals seen: %0d, final record count %0d", full_seen, tbl_count);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_mesh_node_table_engine passed");
        else
            $display("tb_mesh_node_table_engine failed");
        $finish;
    end

endmodule
